[hw/rtl/vmie_pkg.sv]
// ----------------------------------------------------------------------------
// vmie_pkg: shared definitions of the instruction execute unit
// Opcodes, operand kinds, fault codes, beat payload types, the queue entry
// and the state encoding of the execute sequencer.
// ----------------------------------------------------------------------------
package vmie_pkg;

   // Storage geometry.
   localparam int MEM_BYTES   = 16384;
   localparam int MEM_AW      = $clog2(MEM_BYTES);
   localparam int REG_COUNT   = 16;
   localparam int REG_AW      = $clog2(REG_COUNT);
   localparam int DATA_W      = 32;
   localparam int CODE_W      = 15;
   localparam int IP_W        = 16;
   localparam int QUEUE_DEPTH = 2;

   // Signed width that holds base + two 16-bit displacements without overflow.
   localparam int ADDR_CALC_W = 19;

   // Registers with a fixed role.
   localparam logic [REG_AW-1:0] IP_REG = REG_AW'(5);
   localparam logic [REG_AW-1:0] CC_REG = REG_AW'(8);
   localparam logic [REG_AW-1:0] AC_REG = REG_AW'(9);

   // Condition code bit positions.
   localparam int FLAG_N_BIT = 31;
   localparam int FLAG_Z_BIT = 30;

   // Operand kinds.
   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_REG  = 2'd1;
   localparam logic [1:0] KIND_IMM  = 2'd2;
   localparam logic [1:0] KIND_MEM  = 2'd3;

   // Register sectors.
   localparam logic [1:0] SECT_ALL  = 2'd0;
   localparam logic [1:0] SECT_LOW  = 2'd1;
   localparam logic [1:0] SECT_HIGH = 2'd2;
   localparam logic [1:0] SECT_HALF = 2'd3;

   // Opcodes.
   localparam logic [4:0] OP_SYS    = 5'd0;
   localparam logic [4:0] OP_JMP    = 5'd1;
   localparam logic [4:0] OP_JZ     = 5'd2;
   localparam logic [4:0] OP_JP     = 5'd3;
   localparam logic [4:0] OP_JN     = 5'd4;
   localparam logic [4:0] OP_JNZ    = 5'd5;
   localparam logic [4:0] OP_JNP    = 5'd6;
   localparam logic [4:0] OP_JNN    = 5'd7;
   localparam logic [4:0] OP_NOT    = 5'd8;
   localparam logic [4:0] OP_RSV_LO = 5'd9;
   localparam logic [4:0] OP_RSV_HI = 5'd14;
   localparam logic [4:0] OP_STOP   = 5'd15;
   localparam logic [4:0] OP_MOV    = 5'd16;
   localparam logic [4:0] OP_ADD    = 5'd17;
   localparam logic [4:0] OP_SUB    = 5'd18;
   localparam logic [4:0] OP_SWAP   = 5'd19;
   localparam logic [4:0] OP_MUL    = 5'd20;
   localparam logic [4:0] OP_DIV    = 5'd21;
   localparam logic [4:0] OP_CMP    = 5'd22;
   localparam logic [4:0] OP_SHL    = 5'd23;
   localparam logic [4:0] OP_SHR    = 5'd24;
   localparam logic [4:0] OP_AND    = 5'd25;
   localparam logic [4:0] OP_OR     = 5'd26;
   localparam logic [4:0] OP_XOR    = 5'd27;
   localparam logic [4:0] OP_LDL    = 5'd28;
   localparam logic [4:0] OP_LDH    = 5'd29;
   localparam logic [4:0] OP_RND    = 5'd30;
   localparam logic [4:0] OP_LAST   = 5'd31;

   // Fault codes.
   localparam logic [2:0] FAULT_NONE   = 3'd0;
   localparam logic [2:0] FAULT_OPCODE = 3'd1;
   localparam logic [2:0] FAULT_NO_B   = 3'd2;
   localparam logic [2:0] FAULT_BAD_A  = 3'd3;
   localparam logic [2:0] FAULT_DIV0   = 3'd4;
   localparam logic [2:0] FAULT_ADDR   = 3'd5;

   // Request beat.
   typedef struct packed {
      logic [4:0]  command;
      logic [1:0]  type_a;
      logic [1:0]  type_b;
      logic [23:0] operand_a;
      logic [23:0] operand_b;
   } req_payload_type;

   // Response beat.
   typedef struct packed {
      logic [IP_W-1:0]          next_ip;
      logic                     negative_flag;
      logic                     zero_flag;
      logic signed [DATA_W-1:0] written_value;
      logic [2:0]               fault;
      logic                     halted;
   } rsp_payload_type;

   // Classified instruction as it waits between front and back.
   typedef struct packed {
      logic [4:0]  cmd;
      logic [1:0]  ta;
      logic [1:0]  tb;
      logic [23:0] oa;
      logic [23:0] ob;
      logic [2:0]  length;
      logic [2:0]  pre_fault;
      logic        is_stop;
      logic        one_op;
   } ex_entry_type;

   // Execute sequencer states.
   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_START,
      S_RDA,
      S_RDB,
      S_CHECK,
      S_MEMA,
      S_MEMB,
      S_EXEC,
      S_DIV,
      S_WBA,
      S_WBB,
      S_FLAGS,
      S_AC,
      S_HALT,
      S_DONE
   } back_state_type;

endpackage

[hw/rtl/vmie_front.sv]
// ----------------------------------------------------------------------------
// vmie_front: instruction intake and classification
// Takes request beats, works out the instruction length and every fault that
// follows from the opcode and operand kinds alone, and pushes the result.
// ----------------------------------------------------------------------------
module vmie_front
   import vmie_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   input  logic            clearing,
   input  logic            queue_full,
   output logic            push,
   output ex_entry_type    push_entry
);

   logic       bad_op;
   logic       one_op;
   logic [2:0] pre_fault;
   logic       seen_beat_ff;
   logic       seen_beat_in;

   // Nothing enters while memory is being cleared or the queue is full.
   assign req_ready = !clearing && !queue_full;
   assign push      = req_valid && req_ready;

   // Opcode classes.
   always_comb begin
      bad_op = req_payload.command inside {OP_SYS, [OP_RSV_LO:OP_RSV_HI], [OP_RND:OP_LAST]};
      one_op = req_payload.command inside {[OP_JMP:OP_NOT]};
   end

   // Faults that need no register or memory contents.
   always_comb begin
      pre_fault = FAULT_NONE;
      if (bad_op) begin
         pre_fault = FAULT_OPCODE;
      end else if (req_payload.command == OP_STOP) begin
         pre_fault = FAULT_NONE;
      end else if (one_op) begin
         if (req_payload.type_b == KIND_NONE) begin
            pre_fault = FAULT_NO_B;
         end else if (req_payload.command == OP_NOT && req_payload.type_b == KIND_IMM) begin
            pre_fault = FAULT_BAD_A;
         end
      end else begin
         if (req_payload.type_a == KIND_NONE || req_payload.type_a == KIND_IMM) begin
            pre_fault = FAULT_BAD_A;
         end else if (req_payload.type_b == KIND_NONE) begin
            pre_fault = FAULT_NO_B;
         end
      end
   end

   // Queue entry.
   always_comb begin
      push_entry.cmd       = req_payload.command;
      push_entry.ta        = req_payload.type_a;
      push_entry.tb        = req_payload.type_b;
      push_entry.oa        = req_payload.operand_a;
      push_entry.ob        = req_payload.operand_b;
      push_entry.length    = 3'd1 + {1'b0, req_payload.type_a} + {1'b0, req_payload.type_b};
      push_entry.pre_fault = pre_fault;
      push_entry.is_stop   = !bad_op && req_payload.command == OP_STOP;
      push_entry.one_op    = !bad_op && one_op;
   end

   // Tracks whether any beat has been taken since reset.
   assign seen_beat_in = seen_beat_ff || push;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_beat_ff <= 1'b0;
      end else begin
         seen_beat_ff <= seen_beat_in;
      end
   end

   // No beat can be taken during the clearing sweep that follows reset.
   a_no_push_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !push)
      else $error("beat taken during memory clear");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      queue_full |-> !push)
      else $error("beat pushed into a full queue");

   a_clear_first: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !seen_beat_ff)
      else $error("clearing resumed after beats were taken");

endmodule

[hw/rtl/vmie_queue.sv]
// ----------------------------------------------------------------------------
// vmie_queue: short instruction queue
// Holds classified instructions between the front and the execute sequencer
// so that each side can stall on its own.
// ----------------------------------------------------------------------------
module vmie_queue
   import vmie_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  ex_entry_type push_entry,
   input  logic         pop,
   output logic         full,
   output logic         not_empty,
   output ex_entry_type head
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   ex_entry_type     slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   assign full      = count_ff == CNT_W'(QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign head      = slot_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[hw/rtl/vmie_div.sv]
// ----------------------------------------------------------------------------
// vmie_div: serial signed divider
// Restoring division of magnitudes, one quotient bit per cycle, with the
// signs put back afterwards. Quotient truncates toward zero and the
// remainder takes the sign of the dividend.
// ----------------------------------------------------------------------------
module vmie_div
   import vmie_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DATA_W-1:0] dividend,
   input  logic [DATA_W-1:0] divisor,
   output logic              done,
   output logic [DATA_W-1:0] quotient,
   output logic [DATA_W-1:0] remainder
);

   localparam int STEP_W = $clog2(DATA_W);

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] step_ff;
   logic [DATA_W-1:0] quo_ff;
   logic [DATA_W-1:0] rem_ff;
   logic [DATA_W-1:0] den_ff;
   logic              neg_q_ff;
   logic              neg_r_ff;
   logic [DATA_W:0]   rem_shift;
   logic [DATA_W:0]   rem_diff;

   // One restoring step.
   always_comb begin
      rem_shift = {rem_ff, quo_ff[DATA_W-1]};
      rem_diff  = rem_shift - {1'b0, den_ff};
   end

   // Control.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(DATA_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath.
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff   <= dividend[DATA_W-1] ? -dividend : dividend;
         den_ff   <= divisor[DATA_W-1] ? -divisor : divisor;
         rem_ff   <= '0;
         neg_q_ff <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
         neg_r_ff <= dividend[DATA_W-1];
      end else if (busy_ff) begin
         if (!rem_diff[DATA_W]) begin
            rem_ff <= rem_diff[DATA_W-1:0];
            quo_ff <= {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_shift[DATA_W-1:0];
            quo_ff <= {quo_ff[DATA_W-2:0], 1'b0};
         end
      end
   end

   assign done      = done_ff;
   assign quotient  = neg_q_ff ? -quo_ff : quo_ff;
   assign remainder = neg_r_ff ? -rem_ff : rem_ff;

endmodule

[hw/rtl/vmie_back.sv]
// ----------------------------------------------------------------------------
// vmie_back: execute sequencer
// Owns the register file, the byte memory and the halt state. Steps one
// instruction at a time through operand fetch, address checks, memory
// reads, the operation, write-back and condition code update.
// ----------------------------------------------------------------------------
module vmie_back
   import vmie_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_en,
   input  logic [CODE_W-1:0]   csr_write_data,
   input  logic                q_not_empty,
   input  ex_entry_type        q_head,
   output logic                pop,
   output logic                clearing,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_payload_type     rsp_payload
);

   localparam logic [2:0] RD_LAST = 3'd4;
   localparam logic [2:0] WR_LAST = 3'd3;
   localparam logic signed [ADDR_CALC_W-1:0] MEM_TOP = ADDR_CALC_W'(MEM_BYTES - 4);

   back_state_type    state_ff;
   back_state_type    state_in;
   ex_entry_type      cur_ff;
   logic [DATA_W-1:0] regs_ff [REG_COUNT];
   logic [7:0]        mem [MEM_BYTES];
   logic [7:0]        mem_q_ff;
   logic [DATA_W-1:0] raw_a_ff;
   logic [DATA_W-1:0] raw_b_ff;
   logic [DATA_W-1:0] va_ff;
   logic [DATA_W-1:0] vb_ff;
   logic [DATA_W-1:0] res_ff;
   logic [DATA_W-1:0] rem_ff;
   logic [DATA_W-1:0] written_ff;
   logic [MEM_AW-1:0] addr_a_ff;
   logic [MEM_AW-1:0] addr_b_ff;
   logic [2:0]        fault_ff;
   logic              stopped_ff;
   logic [CODE_W-1:0] code_size_ff;
   logic [2:0]        cnt_ff;
   logic [2:0]        cnt_in;
   logic [MEM_AW-1:0] clr_ff;
   logic              rsp_valid_ff;
   rsp_payload_type   rsp_ff;

   logic              a_mem;
   logic              b_mem;
   logic              is_jump;
   logic              sets_flags;
   logic              take_jump;
   logic              out_free;
   logic              wb_is_b;
   logic [1:0]        wb_kind;
   logic [23:0]       wb_op;
   logic [MEM_AW-1:0] wb_addr;
   logic [DATA_W-1:0] wb_val;
   logic              wb_last;
   logic              writes_value;
   logic [DATA_W-1:0] alu_res;

   logic signed [ADDR_CALC_W-1:0] calc_a;
   logic signed [ADDR_CALC_W-1:0] calc_b;
   logic              fail_a;
   logic              fail_b;

   logic              rf_we;
   logic [REG_AW-1:0] rf_idx;
   logic [3:0]        rf_be;
   logic [DATA_W-1:0] rf_data;
   logic              mem_we;
   logic [MEM_AW-1:0] mem_waddr;
   logic [7:0]        mem_wdata;
   logic [MEM_AW-1:0] mem_raddr;
   logic              div_start;
   logic              div_done;
   logic [DATA_W-1:0] div_quot;
   logic [DATA_W-1:0] div_rem;

   // Value of a register or immediate operand.
   function automatic logic [DATA_W-1:0] op_value(input logic [1:0] kind,
                                                  input logic [DATA_W-1:0] raw,
                                                  input logic [23:0] op);
      logic [DATA_W-1:0] v;
      v = '0;
      if (kind == KIND_REG) begin
         case (op[3:2])
            SECT_ALL:  v = raw;
            SECT_LOW:  v = {24'd0, raw[7:0]};
            SECT_HIGH: v = {24'd0, raw[15:8]};
            SECT_HALF: v = {16'd0, raw[15:0]};
            default:   v = raw;
         endcase
      end else if (kind == KIND_IMM) begin
         v = {{16{op[15]}}, op[15:0]};
      end
      return v;
   endfunction

   // Condition code after a result.
   function automatic logic [DATA_W-1:0] next_cc(input logic [DATA_W-1:0] cc,
                                                 input logic [DATA_W-1:0] v);
      logic [DATA_W-1:0] c;
      c = cc;
      if (v[DATA_W-1]) begin
         c[FLAG_N_BIT] = 1'b1;
         c[FLAG_Z_BIT] = 1'b0;
      end else if (v == '0) begin
         c[FLAG_Z_BIT] = 1'b1;
         c[FLAG_N_BIT] = 1'b0;
      end else begin
         c = '0;
      end
      return c;
   endfunction

   // Serial divider.
   vmie_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (va_ff),
      .divisor   (vb_ff),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   // Instruction classes.
   always_comb begin
      a_mem      = !cur_ff.one_op && cur_ff.ta == KIND_MEM;
      b_mem      = cur_ff.tb == KIND_MEM;
      is_jump    = cur_ff.cmd inside {[OP_JMP:OP_JNN]};
      sets_flags = cur_ff.cmd inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CMP, OP_SHL,
                                      OP_SHR, OP_AND, OP_OR, OP_XOR, OP_NOT};
      out_free   = !rsp_valid_ff || rsp_ready;
   end

   // Memory operand addresses: segment base plus two signed displacements.
   always_comb begin
      calc_a = $signed({4'd0, (raw_a_ff[31:16] == 16'd1) ? code_size_ff : CODE_W'(0)})
             + ADDR_CALC_W'($signed(raw_a_ff[15:0]))
             + ADDR_CALC_W'($signed(cur_ff.oa[23:8]));
      calc_b = $signed({4'd0, (raw_b_ff[31:16] == 16'd1) ? code_size_ff : CODE_W'(0)})
             + ADDR_CALC_W'($signed(raw_b_ff[15:0]))
             + ADDR_CALC_W'($signed(cur_ff.ob[23:8]));
      fail_a = a_mem && (raw_a_ff[31:16] > 16'd1 || calc_a < 0 || calc_a > MEM_TOP);
      fail_b = b_mem && (raw_b_ff[31:16] > 16'd1 || calc_b < 0 || calc_b > MEM_TOP);
   end

   // Jump condition from the current condition code.
   always_comb begin
      case (cur_ff.cmd)
         OP_JMP:  take_jump = 1'b1;
         OP_JZ:   take_jump = regs_ff[CC_REG][FLAG_Z_BIT];
         OP_JP:   take_jump = !regs_ff[CC_REG][FLAG_N_BIT] && !regs_ff[CC_REG][FLAG_Z_BIT];
         OP_JN:   take_jump = regs_ff[CC_REG][FLAG_N_BIT];
         OP_JNZ:  take_jump = !regs_ff[CC_REG][FLAG_Z_BIT];
         OP_JNP:  take_jump = regs_ff[CC_REG][FLAG_N_BIT] || regs_ff[CC_REG][FLAG_Z_BIT];
         OP_JNN:  take_jump = !regs_ff[CC_REG][FLAG_N_BIT];
         default: take_jump = 1'b0;
      endcase
   end

   // Operation on the fetched operand values.
   always_comb begin
      writes_value = 1'b1;
      case (cur_ff.cmd)
         OP_ADD:  alu_res = va_ff + vb_ff;
         OP_SUB:  alu_res = va_ff - vb_ff;
         OP_MUL:  alu_res = va_ff * vb_ff;
         OP_SHL:  alu_res = va_ff << vb_ff[4:0];
         OP_SHR:  alu_res = $unsigned($signed(va_ff) >>> vb_ff[4:0]);
         OP_AND:  alu_res = va_ff & vb_ff;
         OP_OR:   alu_res = va_ff | vb_ff;
         OP_XOR:  alu_res = va_ff ^ vb_ff;
         OP_LDL:  alu_res = {va_ff[31:16], vb_ff[15:0]};
         OP_LDH:  alu_res = {vb_ff[15:0], va_ff[15:0]};
         OP_NOT:  alu_res = ~vb_ff;
         OP_CMP: begin
            alu_res      = va_ff - vb_ff;
            writes_value = 1'b0;
         end
         OP_SWAP: begin
            alu_res      = vb_ff;
            writes_value = cur_ff.tb != KIND_IMM;
         end
         OP_DIV: begin
            alu_res      = vb_ff;
            writes_value = 1'b0;
         end
         default: begin
            alu_res      = vb_ff;
            writes_value = !is_jump;
         end
      endcase
   end

   // Write-back target.
   always_comb begin
      wb_is_b = state_ff == S_WBB;
      wb_kind = wb_is_b ? cur_ff.tb : cur_ff.ta;
      wb_op   = wb_is_b ? cur_ff.ob : cur_ff.oa;
      wb_addr = wb_is_b ? addr_b_ff : addr_a_ff;
      wb_val  = (wb_is_b && cur_ff.cmd != OP_NOT) ? va_ff : res_ff;
      wb_last = wb_kind != KIND_MEM || cnt_ff == WR_LAST;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (q_not_empty) begin
               state_in = stopped_ff ? S_DONE : S_START;
            end
         end
         S_START: begin
            if (cur_ff.pre_fault != FAULT_NONE || cur_ff.is_stop) begin
               state_in = S_HALT;
            end else if (cur_ff.one_op) begin
               state_in = S_RDB;
            end else begin
               state_in = S_RDA;
            end
         end
         S_RDA: state_in = S_RDB;
         S_RDB: state_in = S_CHECK;
         S_CHECK: begin
            if (fail_a || fail_b) begin
               state_in = S_HALT;
            end else if (a_mem) begin
               state_in = S_MEMA;
            end else if (b_mem) begin
               state_in = S_MEMB;
            end else begin
               state_in = S_EXEC;
            end
         end
         S_MEMA: begin
            if (cnt_ff == RD_LAST) begin
               state_in = b_mem ? S_MEMB : S_EXEC;
            end
         end
         S_MEMB: begin
            if (cnt_ff == RD_LAST) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (is_jump) begin
               state_in = S_DONE;
            end else if (cur_ff.cmd == OP_DIV) begin
               state_in = (vb_ff == '0) ? S_HALT : S_DIV;
            end else if (cur_ff.cmd == OP_CMP) begin
               state_in = S_FLAGS;
            end else if (cur_ff.cmd == OP_NOT) begin
               state_in = S_WBB;
            end else if (cur_ff.cmd == OP_SWAP && cur_ff.tb == KIND_IMM) begin
               state_in = S_DONE;
            end else begin
               state_in = S_WBA;
            end
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_WBA;
            end
         end
         S_WBA: begin
            if (wb_last) begin
               if (cur_ff.cmd == OP_SWAP) begin
                  state_in = S_WBB;
               end else if (sets_flags) begin
                  state_in = S_FLAGS;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_WBB: begin
            if (wb_last) begin
               state_in = (cur_ff.cmd == OP_NOT) ? S_FLAGS : S_DONE;
            end
         end
         S_FLAGS: state_in = (cur_ff.cmd == OP_DIV) ? S_AC : S_DONE;
         S_AC:    state_in = S_DONE;
         S_HALT:  state_in = S_DONE;
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control outputs per state: register file port, memory ports, divider.
   always_comb begin
      pop       = 1'b0;
      div_start = 1'b0;
      rf_we     = 1'b0;
      rf_idx    = IP_REG;
      rf_be     = 4'b1111;
      rf_data   = '0;
      mem_we    = 1'b0;
      mem_waddr = clr_ff;
      mem_wdata = 8'd0;
      mem_raddr = addr_a_ff + MEM_AW'(cnt_ff[1:0]);
      case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
         end
         S_IDLE: begin
            pop = q_not_empty;
         end
         S_START: begin
            rf_we   = 1'b1;
            rf_data = regs_ff[IP_REG] + DATA_W'(cur_ff.length);
         end
         S_MEMB: begin
            mem_raddr = addr_b_ff + MEM_AW'(cnt_ff[1:0]);
         end
         S_EXEC: begin
            rf_we     = is_jump && take_jump;
            rf_data   = {16'd0, vb_ff[15:0]};
            div_start = cur_ff.cmd == OP_DIV && vb_ff != '0;
         end
         S_WBA, S_WBB: begin
            if (wb_kind == KIND_REG) begin
               rf_we  = 1'b1;
               rf_idx = wb_op[7:4];
               case (wb_op[3:2])
                  SECT_ALL: begin
                     rf_be   = 4'b1111;
                     rf_data = wb_val;
                  end
                  SECT_LOW: begin
                     rf_be   = 4'b0001;
                     rf_data = wb_val;
                  end
                  SECT_HIGH: begin
                     rf_be   = 4'b0010;
                     rf_data = {16'd0, wb_val[7:0], 8'd0};
                  end
                  default: begin
                     rf_be   = 4'b0011;
                     rf_data = wb_val;
                  end
               endcase
            end else if (wb_kind == KIND_MEM) begin
               // Big-endian: the first address takes the top byte.
               mem_we    = 1'b1;
               mem_waddr = wb_addr + MEM_AW'(cnt_ff[1:0]);
               mem_wdata = wb_val[8 * (3 - cnt_ff[1:0]) +: 8];
            end
         end
         S_FLAGS: begin
            rf_we   = 1'b1;
            rf_idx  = CC_REG;
            rf_data = next_cc(regs_ff[CC_REG], res_ff);
         end
         S_AC: begin
            rf_we   = 1'b1;
            rf_idx  = AC_REG;
            rf_data = rem_ff;
         end
         S_HALT: begin
            rf_we   = 1'b1;
            rf_data = DATA_W'(code_size_ff);
         end
         default: begin
            rf_we = 1'b0;
         end
      endcase
   end

   // Step counter for memory byte transfers.
   always_comb begin
      cnt_in = '0;
      if (state_ff == S_MEMA || state_ff == S_MEMB) begin
         cnt_in = (cnt_ff == RD_LAST) ? '0 : cnt_ff + 1'b1;
      end else if ((state_ff == S_WBA || state_ff == S_WBB) && wb_kind == KIND_MEM) begin
         cnt_in = (cnt_ff == WR_LAST) ? '0 : cnt_ff + 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         stopped_ff   <= 1'b0;
         cnt_ff       <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         code_size_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (state_ff == S_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (state_ff == S_HALT) begin
            stopped_ff <= 1'b1;
         end
         if (state_ff == S_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write_en) begin
            code_size_ff <= csr_write_data;
         end
      end
   end

   // Register file: one write port with byte enables.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            regs_ff[i] <= '0;
         end
      end else if (rf_we) begin
         for (int b = 0; b < 4; b++) begin
            if (rf_be[b]) begin
               regs_ff[rf_idx][8 * b +: 8] <= rf_data[8 * b +: 8];
            end
         end
      end
   end

   // Byte memory, registered read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_q_ff <= mem[mem_raddr];
   end

   // Instruction datapath.
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (q_not_empty) begin
               cur_ff     <= q_head;
               written_ff <= '0;
               fault_ff   <= FAULT_NONE;
            end
         end
         S_START: begin
            fault_ff <= cur_ff.pre_fault;
         end
         S_RDA: begin
            raw_a_ff <= regs_ff[cur_ff.oa[7:4]];
         end
         S_RDB: begin
            raw_b_ff <= regs_ff[cur_ff.ob[7:4]];
         end
         S_CHECK: begin
            va_ff     <= op_value(cur_ff.ta, raw_a_ff, cur_ff.oa);
            vb_ff     <= op_value(cur_ff.tb, raw_b_ff, cur_ff.ob);
            addr_a_ff <= calc_a[MEM_AW-1:0];
            addr_b_ff <= calc_b[MEM_AW-1:0];
            if (fail_a || fail_b) begin
               fault_ff <= FAULT_ADDR;
            end
         end
         S_MEMA: begin
            if (cnt_ff != '0) begin
               va_ff <= {va_ff[23:0], mem_q_ff};
            end
         end
         S_MEMB: begin
            if (cnt_ff != '0) begin
               vb_ff <= {vb_ff[23:0], mem_q_ff};
            end
         end
         S_EXEC: begin
            res_ff <= alu_res;
            if (writes_value) begin
               written_ff <= alu_res;
            end
            if (cur_ff.cmd == OP_DIV && vb_ff == '0) begin
               fault_ff <= FAULT_DIV0;
            end
         end
         S_DIV: begin
            if (div_done) begin
               res_ff     <= div_quot;
               written_ff <= div_quot;
               rem_ff     <= div_rem;
            end
         end
         S_HALT: begin
            written_ff <= '0;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_ff.next_ip       <= regs_ff[IP_REG][IP_W-1:0];
               rsp_ff.negative_flag <= regs_ff[CC_REG][FLAG_N_BIT];
               rsp_ff.zero_flag     <= regs_ff[CC_REG][FLAG_Z_BIT];
               rsp_ff.written_value <= $signed(written_ff);
               rsp_ff.fault         <= fault_ff;
               rsp_ff.halted        <= stopped_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign clearing    = state_ff == S_CLEAR;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Only reset leaves the stopped condition.
   a_stop_sticky: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |=> stopped_ff)
      else $error("stopped cleared without reset");

   a_no_pop_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !pop)
      else $error("instruction taken during memory clear");

   a_halt_ip: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_HALT |=> regs_ff[IP_REG] == DATA_W'($past(code_size_ff)))
      else $error("IP not moved to code size on halt");

   a_fault_halts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.fault != FAULT_NONE |-> rsp_ff.halted)
      else $error("fault reported without halt");

endmodule

[hw/rtl/vm_instruction_execute_unit.sv]
// ----------------------------------------------------------------------------
// vm_instruction_execute_unit: register machine instruction executor
//
//   Channel    | Ports                          | Beat
//   -----------+--------------------------------+---------------------------
//   request    | req_valid/req_ready/payload    | one decoded instruction
//   response   | rsp_valid/rsp_ready/payload    | IP, flags, value, fault
//   csr        | csr_write_en/csr_write_data    | code segment length
//
// Memory operands are read and stored through a byte-wide memory port (one
// byte per cycle), and DIV waits on a one-bit-per-cycle serial divider and
// then writes its remainder to AC. After reset the memory is cleared, and
// req_ready stays low until that sweep is done. A two-entry queue lets new
// instructions be taken while one executes or its response waits.
// ----------------------------------------------------------------------------
module vm_instruction_execute_unit
   import vmie_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_payload_type   req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_payload_type   rsp_payload,
   input  logic              csr_write_en,
   input  logic [CODE_W-1:0] csr_write_data
);

   logic         clearing;
   logic         queue_full;
   logic         queue_not_empty;
   logic         push;
   logic         pop;
   ex_entry_type push_entry;
   ex_entry_type head;

   // Intake and classification.
   vmie_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .clearing    (clearing),
      .queue_full  (queue_full),
      .push        (push),
      .push_entry  (push_entry)
   );

   // Decoupling queue.
   vmie_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .not_empty  (queue_not_empty),
      .head       (head)
   );

   // Execution.
   vmie_back u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .q_not_empty    (queue_not_empty),
      .q_head         (head),
      .pop            (pop),
      .clearing       (clearing),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_payload    (rsp_payload)
   );

endmodule
